// ----- design/iepf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iepf_pkg
// Shared constants and types for the ICMP echo parity packet filter.
// ----------------------------------------------------------------------------
package iepf_pkg;

  localparam logic [15:0] EtVlanQ   = 16'h8100;
  localparam logic [15:0] EtVlanAd  = 16'h88A8;
  localparam logic [15:0] EtIpv6    = 16'h86DD;
  localparam logic [15:0] EtIpv4    = 16'h0800;
  localparam logic [7:0]  ProtoIcmp6 = 8'd58;
  localparam logic [7:0]  ProtoIcmp4 = 8'd1;

  localparam logic [1:0]  ClassOther = 2'd0;
  localparam logic [1:0]  ClassIcmp4 = 2'd1;
  localparam logic [1:0]  ClassIcmp6 = 2'd2;

  typedef struct packed {
    logic       drop;
    logic [1:0] packet_class;
  } verdict_t;

endpackage

// ----- design/icmp_echo_parity_packet_filter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_echo_parity_packet_filter_unit
// Byte-serial Ethernet/VLAN/IP/ICMP header walker giving a pass/drop verdict
// on the last byte of each packet.
// ----------------------------------------------------------------------------
// a final byte passes the input register, and its verdict is then stored in the result register
// throughput: one byte per cycle, set by the input register feeding the parser,
// except while a final byte waits for the result register; only final bytes
// produce a result; the result register holds it under stall; reset clears
// parse state and both valid flags; first byte after reset starts a new packet
module icmp_echo_parity_packet_filter_unit #(
  parameter int VLAN_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_packet_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       drop_o,
  output logic [1:0] packet_class_o
);

  logic               in_valid_q;
  logic [7:0]         byte_q;
  logic               eop_q;
  logic               out_valid_q;
  iepf_pkg::verdict_t verdict;
  iepf_pkg::verdict_t result_q;
  logic               out_free;
  logic               step;
  logic               load_in;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  // a final byte waits until the result register can take its verdict
  assign step       = in_valid_q & (~eop_q | out_free);
  assign in_stall_o = in_valid_q & ~step;
  assign load_in    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (~in_valid_q | step) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      byte_q <= data_byte_i;
      eop_q  <= end_of_packet_i;
    end
  end

  iepf_parser #(
    .VLAN_DEPTH(VLAN_DEPTH)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .data_byte_i    (byte_q),
    .end_of_packet_i(eop_q),
    .verdict_o      (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step & eop_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step & eop_q) begin
      result_q <= verdict;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drop_o         = result_q.drop;
  assign packet_class_o = result_q.packet_class;

endmodule

// ----- design/iepf_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iepf_parser
// Header walk state machine: consumes one byte per step and forms the
// verdict from the updated parse state on the final byte.
// ----------------------------------------------------------------------------
module iepf_parser #(
  parameter int VLAN_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_packet_i,
  output iepf_pkg::verdict_t verdict_o
);

  localparam int TagW = (VLAN_DEPTH < 2) ? 1 : $clog2(VLAN_DEPTH + 1);

  typedef enum logic [2:0] {
    PhEth   = 3'd0,
    PhVlan  = 3'd1,
    PhIp6   = 3'd2,
    PhIp4   = 3'd3,
    PhIcmp6 = 3'd4,
    PhIcmp4 = 3'd5,
    PhDone  = 3'd6,
    PhSkip  = 3'd7
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [6:0]      offset_q, offset_d;
  logic [15:0]     ether_type_q, ether_type_d;
  logic [TagW-1:0] tags_q, tags_d;
  logic [7:0]      proto_q, proto_d;
  logic            seq_odd_q, seq_odd_d;
  logic            l2_done;
  logic            vlan_type;
  logic            tag_room;

  assign vlan_type = (ether_type_d == iepf_pkg::EtVlanQ) ||
                     (ether_type_d == iepf_pkg::EtVlanAd);
  assign tag_room  = ({1'b0, tags_d} < (TagW + 1)'(VLAN_DEPTH));

  always_comb begin
    phase_d      = phase_q;
    offset_d     = offset_q;
    ether_type_d = ether_type_q;
    tags_d       = tags_q;
    proto_d      = proto_q;
    seq_odd_d    = seq_odd_q;
    l2_done      = 1'b0;

    unique case (phase_q)
      PhEth: begin
        if (offset_q == 7'd12) ether_type_d = {data_byte_i, 8'h00};
        if (offset_q == 7'd13) begin
          ether_type_d = {ether_type_q[15:8], data_byte_i};
          l2_done      = 1'b1;
        end else begin
          offset_d = offset_q + 7'd1;
        end
      end
      PhVlan: begin
        if (offset_q == 7'd2) ether_type_d = {data_byte_i, 8'h00};
        if (offset_q >= 7'd3) begin
          ether_type_d = {ether_type_q[15:8], data_byte_i};
          tags_d       = tags_q + TagW'(1);
          l2_done      = 1'b1;
        end else begin
          offset_d = offset_q + 7'd1;
        end
      end
      PhIp6: begin
        if (offset_q == 7'd6) proto_d = data_byte_i;
        if (offset_q >= 7'd39) begin
          offset_d = '0;
          phase_d  = (proto_d == iepf_pkg::ProtoIcmp6) ? PhIcmp6 : PhSkip;
        end else begin
          offset_d = offset_q + 7'd1;
        end
      end
      PhIp4: begin
        if (offset_q == 7'd9) proto_d = data_byte_i;
        if (offset_q >= 7'd19) begin
          offset_d = '0;
          phase_d  = (proto_d == iepf_pkg::ProtoIcmp4) ? PhIcmp4 : PhSkip;
        end else begin
          offset_d = offset_q + 7'd1;
        end
      end
      PhIcmp6, PhIcmp4: begin
        if (offset_q >= 7'd7) begin
          seq_odd_d = data_byte_i[0];
          offset_d  = '0;
          phase_d   = PhDone;
        end else begin
          offset_d = offset_q + 7'd1;
        end
      end
      default: ;
    endcase

    // pick the next header once the ethertype is complete
    if (l2_done) begin
      offset_d = '0;
      if (vlan_type && tag_room)                    phase_d = PhVlan;
      else if (ether_type_d == iepf_pkg::EtIpv6)    phase_d = PhIp6;
      else if (ether_type_d == iepf_pkg::EtIpv4)    phase_d = PhIp4;
      else                                          phase_d = PhSkip;
    end
  end

  // verdict from the state after this byte
  always_comb begin
    verdict_o.drop         = 1'b0;
    verdict_o.packet_class = iepf_pkg::ClassOther;
    if (phase_d == PhDone) begin
      if (proto_d == iepf_pkg::ProtoIcmp6) begin
        verdict_o.packet_class = iepf_pkg::ClassIcmp6;
        verdict_o.drop         = ~seq_odd_d;
      end else begin
        verdict_o.packet_class = iepf_pkg::ClassIcmp4;
        verdict_o.drop         = seq_odd_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhEth;
      offset_q     <= '0;
      ether_type_q <= '0;
      tags_q       <= '0;
      proto_q      <= '0;
      seq_odd_q    <= 1'b0;
    end else if (step_i) begin
      if (end_of_packet_i) begin
        phase_q      <= PhEth;
        offset_q     <= '0;
        ether_type_q <= '0;
        tags_q       <= '0;
        proto_q      <= '0;
        seq_odd_q    <= 1'b0;
      end else begin
        phase_q      <= phase_d;
        offset_q     <= offset_d;
        ether_type_q <= ether_type_d;
        tags_q       <= tags_d;
        proto_q      <= proto_d;
        seq_odd_q    <= seq_odd_d;
      end
    end
  end

endmodule
